/* src/ddrh_pkg.sv */
// Shared types and constants for the distance drive ramp and heading hold block.
package ddrh_pkg;

  // Item kinds carried on the input tuser bit
  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } ddrh_op_t;

  // Functions of the shared shift-add/subtract unit
  typedef enum logic {
    FN_MUL = 1'b0,
    FN_DIV = 1'b1
  } ddrh_fn_t;

  // Request from the sequencer to the shared unit
  typedef struct packed {
    logic     start;
    ddrh_fn_t fn;
  } ddrh_req_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_DIST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_GAIN = 3'd6;

  // Field widths
  localparam int DIST_W  = 31;
  localparam int SPD_W   = 17;
  localparam int GAIN_W  = 16;
  localparam int CFG_W   = 31;
  localparam int SPEED_W = 19;

  // Full scale drive command
  localparam int DRIVE_FULL = 65536;

endpackage

/* src/ddrh_shift_unit.sv */
// Shared serial unit: shift-add multiply and restoring divide on one adder.
module ddrh_shift_unit #(
  parameter int AW = 34,
  parameter int BW = 17,
  parameter int QW = 33
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ddrh_pkg::ddrh_req_t     req,
  input  logic [AW-1:0]           mul_a,   // signed multiplicand
  input  logic [BW-1:0]           mul_b,   // unsigned multiplier, left aligned
  input  logic [$clog2(BW+1)-1:0] mul_n,   // multiplier bits to process
  input  logic [QW-1:0]           den,     // divisor, positive
  output logic [AW+BW-1:0]        prod,
  output logic [QW-1:0]           quo,
  output logic                    done
);
  import ddrh_pkg::*;

  localparam int PW = AW + BW;
  localparam int DW = QW + SPD_W;
  localparam int NW = $clog2(((BW > QW) ? BW : QW) + 1);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  ddrh_fn_t       fn_r, fn_nxt;
  logic [NW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]  a_r, a_nxt;
  logic [BW-1:0]  b_r, b_nxt;
  logic [PW-1:0]  acc_r, acc_nxt;
  logic [QW-1:0]  rem_r, rem_nxt;
  logic [QW-1:0]  quo_r, quo_nxt;

  logic [PW-1:0]  a_ext;
  logic [QW:0]    rem2;
  logic [PW-1:0]  op_x;
  logic [PW-1:0]  op_y;
  logic [PW-1:0]  sum;
  logic           fits;

  // One adder: acc*2, plus a when the multiplier bit is set, for multiply; partial remainder - divisor for divide
  assign a_ext = {{BW{a_r[AW-1]}}, a_r};
  assign rem2  = {rem_r, quo_r[QW-1]};
  assign op_x  = (fn_r == FN_DIV) ? {{(PW-QW-1){1'b0}}, rem2} : {acc_r[PW-2:0], 1'b0};
  assign op_y  = (fn_r == FN_DIV) ? ~a_ext : (b_r[BW-1] ? a_ext : '0);
  assign sum   = op_x + op_y + {{(PW-1){1'b0}}, (fn_r == FN_DIV)};
  assign fits  = ~sum[PW-1];

  // Load on request, then step one bit a cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    fn_nxt   = fn_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      fn_nxt   = req.fn;
      if (req.fn == FN_DIV) begin
        a_nxt   = {{(AW-QW){1'b0}}, den};
        rem_nxt = {{(QW-SPD_W){1'b0}}, acc_r[DW-1:QW]};
        quo_nxt = acc_r[QW-1:0];
        cnt_nxt = NW'(QW);
      end else begin
        a_nxt   = mul_a;
        b_nxt   = mul_b;
        acc_nxt = '0;
        cnt_nxt = NW'(mul_n);
      end
    end else if (busy_r) begin
      if (fn_r == FN_DIV) begin
        rem_nxt = fits ? sum[QW-1:0] : rem2[QW-1:0];
        quo_nxt = {quo_r[QW-2:0], fits};
      end else begin
        acc_nxt = sum;
        b_nxt   = {b_r[BW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - NW'(1);
      if (cnt_r == NW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    fn_r  <= fn_nxt;
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign prod = acc_r;
  assign quo  = quo_r;
  assign done = done_r;

endmodule

/* src/distance_drive_ramp_heading_hold_unit.sv */
// Top level: distance drive with trapezoidal speed ramp and heading hold.
//
// A start item (tuser 0) takes the encoder sum as distance zero and the
// heading as the heading to hold, clears the speed and answers with zero
// drives. A tick item (tuser 1) measures the distance, ramps the speed up,
// slows it inside the ramp-down distance, adds the heading correction to the
// left drive and takes it from the right, caps a side above the maximum speed
// by scaling the other side, and answers with both drives saturated to full
// scale. Every item gives exactly one result. All products and quotients go
// through one shared serial unit that handles one multiplier or quotient bit
// per cycle, so the input is not ready while an item is in work. A tick
// runs an extra multiply when the ramp-down applies, and each capped side
// adds a scaling multiply and divide. A result waits in the output register
// until it is taken, and the next item may enter meanwhile.
module distance_drive_ramp_heading_hold_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [95:0]                    in_tdata,  // left_rotations, right_rotations, heading
  input  logic [0:0]                     in_tuser,  // operation
  // Result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [71:0]                    out_tdata, // left_drive, right_drive,
                                                    // heading_error, finished, zero fill
  // Configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ddrh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ddrh_pkg::CFG_W-1:0]     cfg_data
);
  import ddrh_pkg::*;

  // Distance scale pi * 0.1524 / 2 in Q.FRAC_BITS, rounded
  localparam longint KVAL = (64'd2393893104 * (64'd1 << FRAC_BITS) + 64'd5000000000)
                            / 64'd10000000000;
  localparam int KW  = $clog2(KVAL + 1);
  localparam int LRW = 49 - FRAC_BITS;
  localparam int AW  = (LRW + 1 > 34) ? LRW + 1 : 34;
  localparam int BW  = (KW > SPD_W) ? KW : SPD_W;
  localparam int PW  = AW + BW;
  localparam int SHW = PW + 1 - FRAC_BITS;
  localparam int SPW = PW - FRAC_BITS + 1;
  localparam int MCW = $clog2(BW + 1);
  localparam logic [PW:0] RND = (PW+1)'(1) << (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIST,
    S_RAMP,
    S_DROP,
    S_COMP,
    S_CAPL,
    S_CAPL_MUL,
    S_CAPL_DIV,
    S_CAPR,
    S_CAPR_MUL,
    S_CAPR_DIV,
    S_RESULT
  } state_t;

  // Configuration registers
  logic [DIST_W-1:0] tgt_r;
  logic [DIST_W-1:0] rdd_r;
  logic [GAIN_W-1:0] rdg_r;
  logic [SPD_W-1:0]  min_r;
  logic [SPD_W-1:0]  max_r;
  logic [SPD_W-1:0]  step_r;
  logic [GAIN_W-1:0] hg_r;

  // Sequencer and block state
  state_t                   state_r, state_nxt;
  logic                     launched_r, launched_nxt;
  logic signed [32:0]       origin_r, origin_nxt;
  logic signed [31:0]       start_head_r, start_head_nxt;
  logic signed [SPEED_W-1:0] speed_r, speed_nxt;
  logic signed [31:0]       dist_r, dist_nxt;

  // Working registers
  logic signed [32:0]       sum_r, sum_nxt;
  logic signed [31:0]       head_r, head_nxt;
  logic signed [31:0]       err_r, err_nxt;
  logic [31:0]              ovs_r, ovs_nxt;
  logic signed [LRW-1:0]    left_r, left_nxt;
  logic signed [LRW-1:0]    right_r, right_nxt;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic [17:0]              out_left_r, out_left_nxt;
  logic [17:0]              out_right_r, out_right_nxt;
  logic [31:0]              out_err_r, out_err_nxt;
  logic                     out_fin_r, out_fin_nxt;

  // Shared unit
  ddrh_req_t                req;
  logic [AW-1:0]            mul_a;
  logic [BW-1:0]            mul_b;
  logic [MCW-1:0]           mul_n;
  logic [LRW-1:0]           den;
  logic [PW-1:0]            prod;
  logic [LRW-1:0]           quo;
  logic                     done;

  // Datapath helpers
  logic signed [32:0]       in_sum;
  logic signed [33:0]       diff;
  logic [PW:0]              rnd_w;
  logic [SHW-1:0]           dist_wide;
  logic [SHW-32:0]          dist_top;
  logic signed [31:0]       dist_sat;
  logic signed [32:0]       head_diff;
  logic signed [31:0]       err_sat;
  logic signed [33:0]       rem_dist;
  logic signed [33:0]       rdd_ext;
  logic signed [33:0]       ovs_w;
  logic                     ramp;
  logic signed [SPW-1:0]    sp_drop;
  logic signed [SPW-1:0]    min_wide;
  logic signed [19:0]       spd_ext;
  logic signed [19:0]       min_ext;
  logic signed [19:0]       max_ext;
  logic signed [19:0]       spd_step;
  logic signed [LRW-1:0]    comp;
  logic signed [LRW-1:0]    spd_lr;
  logic signed [LRW-1:0]    max_lr;
  logic signed [LRW-1:0]    mag_src;
  logic [LRW-1:0]           mag;
  logic [LRW-1:0]           q_signed;
  logic signed [LRW-1:0]    full_pos;
  logic signed [LRW-1:0]    full_neg;
  logic [17:0]              left_clamp;
  logic [17:0]              right_clamp;
  logic                     fin_now;
  logic                     in_accept;
  logic                     out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // Encoder sum and distance from the last product
  assign in_sum    = {in_tdata[31], in_tdata[31:0]} + {in_tdata[63], in_tdata[63:32]};
  assign diff      = {sum_r[32], sum_r} - {origin_r[32], origin_r};
  assign rnd_w     = {prod[PW-1], prod} + RND;
  assign dist_wide = rnd_w[PW:FRAC_BITS];
  assign dist_top  = dist_wide[SHW-1:31];
  assign dist_sat  = (&dist_top || ~|dist_top) ? dist_wide[31:0] :
                     (dist_wide[SHW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);

  // Heading error, saturated
  assign head_diff = {head_r[31], head_r} - {start_head_r[31], start_head_r};
  assign err_sat   = (head_diff[32] == head_diff[31]) ? head_diff[31:0] :
                     (head_diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff);

  // Remaining distance and overshoot into the ramp-down zone
  assign rem_dist = {3'b000, tgt_r} - {{2{dist_r[31]}}, dist_r};
  assign rdd_ext  = {3'b000, rdd_r};
  assign ramp     = rem_dist < rdd_ext;
  assign ovs_w    = rdd_ext - rem_dist;

  // Speed after the ramp-down drop, and the ramp-up path
  assign sp_drop  = {{(SPW-SPEED_W){speed_r[SPEED_W-1]}}, speed_r}
                    - {1'b0, prod[PW-1:FRAC_BITS]};
  assign min_wide = {{(SPW-SPD_W){1'b0}}, min_r};
  assign spd_ext  = {speed_r[SPEED_W-1], speed_r};
  assign min_ext  = {3'b000, min_r};
  assign max_ext  = {3'b000, max_r};
  assign spd_step = spd_ext + {3'b000, step_r};

  // Heading correction and side values
  assign comp   = prod[FRAC_BITS +: LRW];
  assign spd_lr = {{(LRW-SPEED_W){speed_r[SPEED_W-1]}}, speed_r};
  assign max_lr = {{(LRW-SPD_W){1'b0}}, max_r};

  // Magnitude of the side to scale, and the signed quotient
  assign mag_src  = (state_r == S_CAPL_MUL || state_r == S_CAPL_DIV) ? right_r : left_r;
  assign mag      = mag_src[LRW-1] ? (~mag_src + 1'b1) : mag_src;
  assign q_signed = mag_src[LRW-1] ? (~quo + 1'b1) : quo;

  // Output saturation
  assign full_pos    = LRW'(DRIVE_FULL);
  assign full_neg    = -full_pos;
  assign left_clamp  = (left_r > full_pos) ? full_pos[17:0] :
                       ((left_r < full_neg) ? full_neg[17:0] : left_r[17:0]);
  assign right_clamp = (right_r > full_pos) ? full_pos[17:0] :
                       ((right_r < full_neg) ? full_neg[17:0] : right_r[17:0]);
  assign fin_now     = $signed({dist_r[31], dist_r}) >= $signed({2'b00, tgt_r});

  // Shared unit operands per step
  always_comb begin
    req.start = 1'b0;
    req.fn    = FN_MUL;
    mul_a     = '0;
    mul_b     = '0;
    mul_n     = '0;
    den       = '0;
    case (state_r)
      S_DIST: begin
        req.start = !launched_r;
        mul_a     = {{(AW-34){diff[33]}}, diff};
        mul_b     = BW'(KVAL) << (BW - KW);
        mul_n     = MCW'(KW);
      end
      S_DROP: begin
        req.start = !launched_r;
        mul_a     = {{(AW-32){1'b0}}, ovs_r};
        mul_b     = BW'(rdg_r) << (BW - GAIN_W);
        mul_n     = MCW'(GAIN_W);
      end
      S_COMP: begin
        req.start = !launched_r;
        mul_a     = {{(AW-32){err_r[31]}}, err_r};
        mul_b     = BW'(hg_r) << (BW - GAIN_W);
        mul_n     = MCW'(GAIN_W);
      end
      S_CAPL_MUL, S_CAPR_MUL: begin
        req.start = !launched_r;
        mul_a     = {{(AW-LRW){1'b0}}, mag};
        mul_b     = BW'(max_r) << (BW - SPD_W);
        mul_n     = MCW'(SPD_W);
      end
      S_CAPL_DIV: begin
        req.start = !launched_r;
        req.fn    = FN_DIV;
        den       = left_r;
      end
      S_CAPR_DIV: begin
        req.start = !launched_r;
        req.fn    = FN_DIV;
        den       = right_r;
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    launched_nxt   = launched_r;
    origin_nxt     = origin_r;
    start_head_nxt = start_head_r;
    speed_nxt      = speed_r;
    dist_nxt       = dist_r;
    sum_nxt        = sum_r;
    head_nxt       = head_r;
    err_nxt        = err_r;
    ovs_nxt        = ovs_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    out_valid_nxt  = out_valid_r;
    out_left_nxt   = out_left_r;
    out_right_nxt  = out_right_r;
    out_err_nxt    = out_err_r;
    out_fin_nxt    = out_fin_r;

    // Drop the result once it is transferred
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Track an outstanding unit operation
    if (req.start) begin
      launched_nxt = 1'b1;
    end else if (done) begin
      launched_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_tuser[0] == OP_START) begin
            origin_nxt     = in_sum;
            start_head_nxt = in_tdata[95:64];
            speed_nxt      = '0;
            dist_nxt       = '0;
            err_nxt        = '0;
            left_nxt       = '0;
            right_nxt      = '0;
            state_nxt      = S_RESULT;
          end else begin
            sum_nxt   = in_sum;
            head_nxt  = in_tdata[95:64];
            state_nxt = S_DIST;
          end
        end
      end
      S_DIST: begin
        if (done) begin
          dist_nxt  = dist_sat;
          err_nxt   = err_sat;
          state_nxt = S_RAMP;
        end
      end
      S_RAMP: begin
        ovs_nxt = ovs_w[31:0];
        if (ramp) begin
          state_nxt = S_DROP;
        end else begin
          if (spd_ext < min_ext) begin
            speed_nxt = SPEED_W'(min_r);
          end else if (spd_ext < max_ext) begin
            speed_nxt = spd_step[SPEED_W-1:0];
          end else begin
            speed_nxt = SPEED_W'(max_r);
          end
          state_nxt = S_COMP;
        end
      end
      S_DROP: begin
        if (done) begin
          speed_nxt = (sp_drop < min_wide) ? SPEED_W'(min_r) : sp_drop[SPEED_W-1:0];
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        if (done) begin
          left_nxt  = spd_lr + comp;
          right_nxt = spd_lr - comp;
          state_nxt = S_CAPL;
        end
      end
      S_CAPL: begin
        state_nxt = (left_r > max_lr) ? S_CAPL_MUL : S_CAPR;
      end
      S_CAPL_MUL: begin
        if (done) begin
          state_nxt = S_CAPL_DIV;
        end
      end
      S_CAPL_DIV: begin
        if (done) begin
          right_nxt = q_signed;
          left_nxt  = max_lr;
          state_nxt = S_CAPR;
        end
      end
      S_CAPR: begin
        state_nxt = (right_r > max_lr) ? S_CAPR_MUL : S_RESULT;
      end
      S_CAPR_MUL: begin
        if (done) begin
          state_nxt = S_CAPR_DIV;
        end
      end
      S_CAPR_DIV: begin
        if (done) begin
          left_nxt  = q_signed;
          right_nxt = max_lr;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        // Hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = left_clamp;
          out_right_nxt = right_clamp;
          out_err_nxt   = err_r;
          out_fin_nxt   = fin_now;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      launched_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      origin_r     <= '0;
      start_head_r <= '0;
      speed_r      <= '0;
      dist_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      launched_r   <= launched_nxt;
      out_valid_r  <= out_valid_nxt;
      origin_r     <= origin_nxt;
      start_head_r <= start_head_nxt;
      speed_r      <= speed_nxt;
      dist_r       <= dist_nxt;
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk) begin
    sum_r       <= sum_nxt;
    head_r      <= head_nxt;
    err_r       <= err_nxt;
    ovs_r       <= ovs_nxt;
    left_r      <= left_nxt;
    right_r     <= right_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_err_r   <= out_err_nxt;
    out_fin_r   <= out_fin_nxt;
  end

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r  <= '0;
      rdd_r  <= DIST_W'(65536);
      rdg_r  <= '0;
      min_r  <= '0;
      max_r  <= SPD_W'(65536);
      step_r <= '0;
      hg_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET:    tgt_r  <= cfg_data[DIST_W-1:0];
        REG_RAMP_DIST: rdd_r  <= cfg_data[DIST_W-1:0];
        REG_RAMP_GAIN: rdg_r  <= cfg_data[GAIN_W-1:0];
        REG_MIN_SPEED: min_r  <= cfg_data[SPD_W-1:0];
        REG_MAX_SPEED: max_r  <= cfg_data[SPD_W-1:0];
        REG_STEP:      step_r <= cfg_data[SPD_W-1:0];
        REG_HEAD_GAIN: hg_r   <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ddrh_shift_unit #(
    .AW (AW),
    .BW (BW),
    .QW (LRW)
  ) u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_n (mul_n),
    .den   (den),
    .prod  (prod),
    .quo   (quo),
    .done  (done)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_fin_r, out_err_r, out_right_r, out_left_r};

endmodule
